// ----- rtl/u8sd_pkg.sv -----
// u8sd_pkg: shared types and constants for the UTF-8 stream decoder.
// Holds the queue job format between the front and back ends.
// No dependencies.
package u8sd_pkg;

    localparam int BYTE_W     = 8;
    localparam int CP_W       = 21;
    localparam int CNT_W      = 3;
    localparam int REP_W      = 2;

    // decoded-job queue, depth must be a power of two
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    // byte classes and code points
    localparam logic [CP_W-1:0]   REPL_CP    = 21'h00FFFD;
    localparam logic [BYTE_W-1:0] CONT_MASK  = 8'hC0;
    localparam logic [BYTE_W-1:0] CONT_TAG   = 8'h80;
    localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD2_TAG  = 8'hC0;
    localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'hF0;
    localparam logic [BYTE_W-1:0] LEAD3_TAG  = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'hF8;
    localparam logic [BYTE_W-1:0] LEAD4_TAG  = 8'hF0;

    // sequence lengths
    localparam logic [CNT_W-1:0] LEN_END  = 3'd0;
    localparam logic [CNT_W-1:0] LEN_ONE  = 3'd1;
    localparam logic [CNT_W-1:0] LEN_TWO  = 3'd2;
    localparam logic [CNT_W-1:0] LEN_THREE = 3'd3;
    localparam logic [CNT_W-1:0] LEN_FOUR = 3'd4;

    // one classified input byte: rep replacement results, then an optional tail
    typedef struct packed {
        logic [REP_W-1:0] rep;
        logic             tail_vld;
        logic [CP_W-1:0]  tail_cp;
        logic [CNT_W-1:0] tail_cnt;
    } t_job;

endpackage

// ----- rtl/u8sd_front.sv -----
// u8sd_front: accepts bytes, tracks the open UTF-8 sequence and classifies
// each byte into a job for the back end. Depends on u8sd_pkg.
module u8sd_front import u8sd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [BYTE_W-1:0] i_byte,
    output logic              o_job_we,
    output t_job              o_job
);

    logic [CP_W-1:0]  r_partial, n_partial;
    logic [CNT_W-1:0] r_exp, n_exp;
    logic [REP_W-1:0] r_taken, n_taken;

    // lead decode of the incoming byte
    logic             lead_tail;
    logic [CP_W-1:0]  lead_cp;
    logic [CNT_W-1:0] lead_cnt;
    logic             lead_open;
    logic [CNT_W-1:0] lead_exp;
    logic [CP_W-1:0]  lead_part;

    always_comb begin
        lead_tail = 1'b1;
        lead_cp   = REPL_CP;
        lead_cnt  = LEN_ONE;
        lead_open = 1'b0;
        lead_exp  = LEN_END;
        lead_part = '0;
        if (i_byte == '0) begin
            lead_cp  = '0;
            lead_cnt = LEN_END;
        end else if (!i_byte[BYTE_W-1]) begin
            lead_cp = CP_W'(i_byte);
        end else if ((i_byte & LEAD2_MASK) == LEAD2_TAG) begin
            lead_tail = 1'b0;
            lead_open = 1'b1;
            lead_exp  = LEN_TWO;
            lead_part = CP_W'(i_byte[4:0]);
        end else if ((i_byte & LEAD3_MASK) == LEAD3_TAG) begin
            lead_tail = 1'b0;
            lead_open = 1'b1;
            lead_exp  = LEN_THREE;
            lead_part = CP_W'(i_byte[3:0]);
        end else if ((i_byte & LEAD4_MASK) == LEAD4_TAG) begin
            lead_tail = 1'b0;
            lead_open = 1'b1;
            lead_exp  = LEN_FOUR;
            lead_part = CP_W'(i_byte[2:0]);
        end
    end

    // sequence tracking and job build
    logic             is_cont;
    logic [CP_W-1:0]  shifted;
    logic [REP_W-1:0] taken_inc;

    assign is_cont   = (i_byte & CONT_MASK) == CONT_TAG;
    assign shifted   = {r_partial[CP_W-7:0], i_byte[5:0]};
    assign taken_inc = r_taken + 2'd1;

    always_comb begin
        n_partial      = r_partial;
        n_exp          = r_exp;
        n_taken        = r_taken;
        o_job.rep      = '0;
        o_job.tail_vld = lead_tail;
        o_job.tail_cp  = lead_cp;
        o_job.tail_cnt = lead_cnt;
        if (r_exp == LEN_END || !is_cont) begin
            // no sequence open, or an open one broken by a non-continuation
            if (r_exp != LEN_END) begin
                o_job.rep = r_taken;
            end
            n_partial = lead_part;
            n_exp     = lead_exp;
            n_taken   = lead_open ? REP_W'(1) : '0;
        end else begin
            // continuation byte appends six bits
            n_partial      = shifted;
            n_taken        = taken_inc;
            o_job.tail_vld = 1'b0;
            o_job.tail_cp  = shifted;
            o_job.tail_cnt = r_exp;
            if (taken_inc == '0 || {1'b0, taken_inc} >= r_exp) begin
                o_job.tail_vld = 1'b1;
                n_partial      = '0;
                n_exp          = LEN_END;
                n_taken        = '0;
            end
        end
    end

    assign o_job_we = i_accept && (o_job.rep != '0 || o_job.tail_vld);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_partial <= '0;
            r_exp     <= LEN_END;
            r_taken   <= '0;
        end else if (i_accept) begin
            r_partial <= n_partial;
            r_exp     <= n_exp;
            r_taken   <= n_taken;
        end
    end

    // no sequence open means nothing taken; an open one has its lead
    a_idle_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_exp == LEN_END) |-> (r_taken == '0))
        else $error("front: bytes counted with no sequence open");

    a_open_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_exp != LEN_END) |-> (r_taken != '0 && {1'b0, r_taken} < r_exp
                                && r_exp != LEN_ONE))
        else $error("front: open sequence count out of range");

endmodule

// ----- rtl/u8sd_queue.sv -----
// u8sd_queue: short job queue between the front and back ends.
// Register array with read and write pointers. Depends on u8sd_pkg.
module u8sd_queue import u8sd_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output t_job o_job,
    output logic o_empty
);

    t_job                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr;
    logic [QUEUE_CW-1:0] r_cnt;

    assign o_full  = r_cnt == QUEUE_CW'(QUEUE_DEPTH);
    assign o_empty = r_cnt == '0;
    assign o_job   = r_mem[r_rd_ptr];

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (i_push) r_wr_ptr <= r_wr_ptr + QUEUE_AW'(1);
            if (i_pop)  r_rd_ptr <= r_rd_ptr + QUEUE_AW'(1);
            if (i_push && !i_pop)      r_cnt <= r_cnt + QUEUE_CW'(1);
            else if (i_pop && !i_push) r_cnt <= r_cnt - QUEUE_CW'(1);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("queue: push while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty))
        else $error("queue: pop while empty");

endmodule

// ----- rtl/u8sd_back.sv -----
// u8sd_back: expands queued jobs into result items, one per cycle while the
// receiver keeps popping, into an output register. Depends on u8sd_pkg.
module u8sd_back import u8sd_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_job             i_job,
    input  logic             i_q_empty,
    output logic             o_q_pop,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [CP_W-1:0]  o_code_point,
    output logic [CNT_W-1:0] o_byte_count,
    output logic             o_last
);

    logic             r_out_vld;
    logic [CP_W-1:0]  r_cp;
    logic [CNT_W-1:0] r_cnt;
    logic             r_last;
    logic [REP_W-1:0] r_idx;

    logic             load;
    logic             rep_done;
    logic [CP_W-1:0]  cur_cp;
    logic [CNT_W-1:0] cur_cnt;
    logic             cur_last;

    // pick the next result of the head job
    assign rep_done = r_idx == i_job.rep;
    always_comb begin
        if (rep_done) begin
            cur_cp   = i_job.tail_cp;
            cur_cnt  = i_job.tail_cnt;
            cur_last = 1'b1;
        end else begin
            cur_cp   = REPL_CP;
            cur_cnt  = LEN_ONE;
            cur_last = (r_idx == i_job.rep - REP_W'(1)) && !i_job.tail_vld;
        end
    end

    assign load    = !i_q_empty && (!r_out_vld || i_pop);
    assign o_q_pop = load && cur_last;

    // job position counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (load) begin
            r_idx <= cur_last ? '0 : r_idx + REP_W'(1);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (load) begin
            r_out_vld <= 1'b1;
        end else if (i_pop) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_cp   <= cur_cp;
            r_cnt  <= cur_cnt;
            r_last <= cur_last;
        end
    end

    assign o_empty      = !r_out_vld;
    assign o_code_point = r_cp;
    assign o_byte_count = r_cnt;
    assign o_last       = r_last;

    // a job part way through stays at the head of the queue
    a_rest_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !r_last) |-> !i_q_empty)
        else $error("back: job tail missing after non-final result");

    a_idx_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_idx != '0) |-> (!i_q_empty && r_idx <= i_job.rep))
        else $error("back: job position beyond head job");

endmodule

// ----- rtl/utf8_stream_decoder.sv -----
// utf8_stream_decoder: top level of the streaming UTF-8 decoder.
// Instantiates u8sd_front, u8sd_queue and u8sd_back; uses u8sd_pkg.
//
// Usage:
//   Input queue port: drive i_byte_in and raise i_push; the byte is taken
//   at a clock edge where i_push is high and o_full is low.
//   Result queue port: while o_empty is low, o_code_point, o_byte_count
//   and o_last show the oldest result; it is taken at an edge where i_pop
//   is high. o_last marks the final result caused by one input byte.
//   Lead bytes that open a sequence produce no result of their own.
// Path: a completing byte writes its job into the job queue as it is
//   taken; the back end then loads the result into the output register.
// Throughput: one byte per cycle while each byte yields at most one
//   result and results are popped. A broken sequence yields up to four
//   results, emitted one per cycle while popped; the four-entry job queue
//   absorbs such bursts and o_full rises only once it fills.
// Reset (synchronous, i_rst_n low): no sequence open, queue and output
//   register empty.
// Receiver stall: the output holds until popped; the queue keeps taking
//   bytes until it is full.
module utf8_stream_decoder import u8sd_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    output logic             o_full,
    input  logic [BYTE_W-1:0] i_byte_in,
    output logic             o_empty,
    input  logic             i_pop,
    output logic [CP_W-1:0]  o_code_point,
    output logic [CNT_W-1:0] o_byte_count,
    output logic             o_last
);

    logic accept;
    logic job_we;
    t_job front_job;
    t_job head_job;
    logic q_empty;
    logic q_pop;

    assign accept = i_push && !o_full;

    u8sd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (i_byte_in),
        .o_job_we (job_we),
        .o_job    (front_job)
    );

    u8sd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_we),
        .i_job   (front_job),
        .o_full  (o_full),
        .i_pop   (q_pop),
        .o_job   (head_job),
        .o_empty (q_empty)
    );

    u8sd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job        (head_job),
        .i_q_empty    (q_empty),
        .o_q_pop      (q_pop),
        .i_pop        (i_pop),
        .o_empty      (o_empty),
        .o_code_point (o_code_point),
        .o_byte_count (o_byte_count),
        .o_last       (o_last)
    );

endmodule
